/* hw/rtl/qlu_pkg.sv */
// Package with item types, phase codes, character codes and helper functions.
package qlu_pkg;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_last;
	} unit_item_t;

	typedef struct packed {
		logic [15:0] decoded_unit;
		logic        has_unit;
		logic        end_of_literal;
	} dec_item_t;

	typedef enum logic [1:0] {
		PH_OPEN = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	localparam logic [15:0] CH_BSLASH  = 16'h005C;
	localparam logic [15:0] CH_SMALL_U = 16'h0075;
	localparam logic [15:0] CH_SMALL_N = 16'h006E;
	localparam logic [15:0] CH_SMALL_R = 16'h0072;
	localparam logic [15:0] CH_SMALL_T = 16'h0074;
	localparam logic [15:0] CH_ZERO    = 16'h0030;
	localparam logic [15:0] CH_NINE    = 16'h0039;
	localparam logic [15:0] CH_SMALL_A = 16'h0061;
	localparam logic [15:0] CH_SMALL_B = 16'h0062;
	localparam logic [15:0] CH_SMALL_F = 16'h0066;
	localparam logic [15:0] CH_SMALL_Z = 16'h007A;
	localparam logic [15:0] CH_BIG_A   = 16'h0041;
	localparam logic [15:0] CH_BIG_F   = 16'h0046;
	localparam logic [15:0] CH_BIG_X   = 16'h0058;
	localparam logic [15:0] CASE_DIFF  = 16'h0020;

	localparam logic [15:0] CTL_NUL = 16'h0000;
	localparam logic [15:0] CTL_BEL = 16'h0007;
	localparam logic [15:0] CTL_BS  = 16'h0008;
	localparam logic [15:0] CTL_HT  = 16'h0009;
	localparam logic [15:0] CTL_LF  = 16'h000A;
	localparam logic [15:0] CTL_FF  = 16'h000C;
	localparam logic [15:0] CTL_CR  = 16'h000D;

	// Uppercase ASCII letters, leave everything else.
	function automatic logic [15:0] to_upper(input logic [15:0] c);
		if (c >= CH_SMALL_A && c <= CH_SMALL_Z) begin
			return c - CASE_DIFF;
		end
		return c;
	endfunction

	// Return {is_digit, nibble} for an uppercase hex digit.
	function automatic logic [4:0] hex_digit(input logic [15:0] c);
		logic [15:0] d;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			return {1'b1, d[3:0]};
		end
		if (c >= CH_BIG_A && c <= CH_BIG_F) begin
			d = c - CH_BIG_A + 16'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	// Map the unit after a backslash to its control code.
	function automatic logic [15:0] map_escape(input logic [15:0] c);
		case (c)
			CH_ZERO:    return CTL_NUL;
			CH_SMALL_A: return CTL_BEL;
			CH_SMALL_B: return CTL_BS;
			CH_SMALL_F: return CTL_FF;
			CH_SMALL_N: return CTL_LF;
			CH_SMALL_R: return CTL_CR;
			CH_SMALL_T: return CTL_HT;
			default:    return c;
		endcase
	endfunction

endpackage

/* hw/rtl/quoted_literal_unescape_core.sv */
// Quoted literal escape decoder: input register, decode logic, result register.
// An accepted input item goes through the input register, then the result register.
// Throughput: one input item per cycle unless dec_stall holds a result; phase
// and hex-unit registers update in the same cycle the registered item is decoded.
// Items that close nothing and decode nothing (quotes, backslash) give no result.
// Reset (arst_n low, asynchronous): both stages empty, phase awaits opening quote.
module quoted_literal_unescape_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   unit_valid,
	output logic                   unit_stall,
	input  qlu_pkg::unit_item_t    unit_item,
	output logic                   dec_valid,
	input  logic                   dec_stall,
	output qlu_pkg::dec_item_t     dec_item
);
	import qlu_pkg::*;

	localparam int HEX_DEPTH = 4;

	logic        valid_s1;
	unit_item_t  item_s1;
	logic        adv_s1;
	logic        fire;

	phase_t      phase_q, phase_d;
	logic [2:0]  hex_seen_q, hex_seen_d;
	logic [15:0] hex_units_q [HEX_DEPTH];

	logic [15:0] up_unit;
	logic [15:0] units_c [HEX_DEPTH];
	logic [2:0]  hex_n;
	logic [15:0] hex_acc;
	logic        emit;
	logic        have;
	logic [15:0] val;

	logic        res_valid_q;
	dec_item_t   res_item_q;

	// Advance the input stage whenever the result register is free or drains.
	assign adv_s1     = !res_valid_q || !dec_stall;
	assign fire       = valid_s1 && adv_s1;
	assign unit_stall = valid_s1 && !adv_s1;

	// Hold the input item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!unit_stall) begin
			valid_s1 <= unit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!unit_stall) begin
			item_s1 <= unit_item;
		end
	end

	// Merge the current unit into the hex units and read the number.
	always_comb begin
		logic go;
		logic [2:0] start;
		logic [4:0] dig;
		up_unit = to_upper(item_s1.code_unit);
		for (int i = 0; i < HEX_DEPTH; i++) begin
			units_c[i] = hex_units_q[i];
		end
		units_c[hex_seen_q[1:0]] = up_unit;
		hex_n   = hex_seen_q + 3'd1;
		go      = 1'b1;
		hex_acc = 16'd0;
		start   = 3'd0;
		if (hex_n >= 3'd2 && units_c[0] == CH_ZERO && units_c[1] == CH_BIG_X) begin
			start = 3'd2;
		end
		for (int p = 0; p < HEX_DEPTH; p++) begin
			dig = hex_digit(units_c[p]);
			if (go && 3'(p) >= start && 3'(p) < hex_n) begin
				if (dig[4]) begin
					hex_acc = {hex_acc[11:0], dig[3:0]};
				end else begin
					go = 1'b0;
				end
			end
		end
	end

	// Decide next phase and the result of the registered item.
	always_comb begin
		phase_d    = phase_q;
		hex_seen_d = hex_seen_q;
		have       = 1'b0;
		val        = 16'd0;
		case (phase_q)
			PH_BODY: begin
				if (item_s1.is_last) begin
					phase_d = PH_BODY;
				end else if (item_s1.code_unit == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					have = 1'b1;
					val  = item_s1.code_unit;
				end
			end
			PH_ESC: begin
				if (item_s1.code_unit == CH_SMALL_U) begin
					hex_seen_d = 3'd0;
					if (item_s1.is_last) begin
						have = 1'b1;
					end else begin
						phase_d = PH_HEX;
					end
				end else begin
					have    = 1'b1;
					val     = map_escape(item_s1.code_unit);
					phase_d = PH_BODY;
				end
			end
			PH_HEX: begin
				hex_seen_d = hex_n;
				if (hex_n >= 3'(HEX_DEPTH) || item_s1.is_last) begin
					have       = 1'b1;
					val        = hex_acc;
					hex_seen_d = 3'd0;
					phase_d    = PH_BODY;
				end
			end
			default: begin
				phase_d = PH_BODY;
			end
		endcase
		if (item_s1.is_last) begin
			phase_d = PH_OPEN;
		end
		emit = have || item_s1.is_last;
	end

	// Update decode state when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPEN;
			hex_seen_q <= 3'd0;
		end else if (fire) begin
			phase_q    <= phase_d;
			hex_seen_q <= hex_seen_d;
		end
	end

	// Store the uppercased hex unit.
	always_ff @(posedge clk) begin
		if (fire && phase_q == PH_HEX) begin
			hex_units_q[hex_seen_q[1:0]] <= up_unit;
		end
	end

	// Load or drain the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_item_q.decoded_unit   <= val;
			res_item_q.has_unit       <= have;
			res_item_q.end_of_literal <= item_s1.is_last;
		end
	end

	assign dec_valid = res_valid_q;
	assign dec_item  = res_item_q;

`ifndef SYNTHESIS
	// An empty result only closes a literal and carries a zero unit.
	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_item.has_unit |-> dec_item.end_of_literal &&
		dec_item.decoded_unit == 16'd0)
		else $error("result without unit does not close a literal");

	// A final unit always returns the decoder to the opening phase.
	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.is_last |=> phase_q == PH_OPEN)
		else $error("phase not back to open after final unit");

	// The hex count never stays at the full depth.
	a_hex_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEX |-> hex_seen_q < 3'(HEX_DEPTH))
		else $error("hex unit count overflow");

	// Stall the source only when an item is held.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		unit_stall |-> valid_s1 && res_valid_q && dec_stall)
		else $error("input stalled with free pipeline");
`endif

endmodule

/* bench/quoted_literal_unescape_core_test.sv */
// Self-checking bench for the quoted literal escape decoder with random gaps and stalls.
module quoted_literal_unescape_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import qlu_pkg::*;

	localparam realtime     CLK_HALF     = 2.0;
	localparam int unsigned ITEM_TARGET  = 1900;
	localparam int unsigned HOLD_CYCLES  = 100;
	localparam int unsigned LIMIT_CYCLES = 600000;
	localparam int unsigned DRAIN_CYCLES = 8;

	// Character codes used by the literal generator and the decoder model
	localparam logic [15:0] ASC_DQUOTE = 16'h0022;
	localparam logic [15:0] ASC_QUOTE  = 16'h0027;
	localparam logic [15:0] ASC_0      = 16'h0030;
	localparam logic [15:0] ASC_9      = 16'h0039;
	localparam logic [15:0] ASC_A_UP   = 16'h0041;
	localparam logic [15:0] ASC_F_UP   = 16'h0046;
	localparam logic [15:0] ASC_X_UP   = 16'h0058;
	localparam logic [15:0] ASC_BSLASH = 16'h005C;
	localparam logic [15:0] ASC_A_LO   = 16'h0061;
	localparam logic [15:0] ASC_B_LO   = 16'h0062;
	localparam logic [15:0] ASC_F_LO   = 16'h0066;
	localparam logic [15:0] ASC_G_LO   = 16'h0067;
	localparam logic [15:0] ASC_N_LO   = 16'h006E;
	localparam logic [15:0] ASC_R_LO   = 16'h0072;
	localparam logic [15:0] ASC_T_LO   = 16'h0074;
	localparam logic [15:0] ASC_U_LO   = 16'h0075;
	localparam logic [15:0] ASC_X_LO   = 16'h0078;
	localparam logic [15:0] ASC_Z_LO   = 16'h007A;
	localparam logic [15:0] ASC_CASE   = 16'h0020;

	localparam logic [15:0] CTRL_NUL = 16'h0000;
	localparam logic [15:0] CTRL_BEL = 16'h0007;
	localparam logic [15:0] CTRL_BS  = 16'h0008;
	localparam logic [15:0] CTRL_HT  = 16'h0009;
	localparam logic [15:0] CTRL_LF  = 16'h000A;
	localparam logic [15:0] CTRL_FF  = 16'h000C;
	localparam logic [15:0] CTRL_CR  = 16'h000D;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       unit_valid = 1'b0;
	logic       unit_stall;
	unit_item_t unit_item = '0;
	logic       dec_valid;
	logic       dec_stall = 1'b0;
	dec_item_t  dec_item;

	unit_item_t  unit_backlog[$];
	dec_item_t   dec_expected[$];
	dec_item_t   want_item;
	int unsigned queued_units = 0;
	int unsigned mismatches = 0;
	logic [31:0] items_sent = '0;
	logic [31:0] results_seen = '0;
	int unsigned send_idle = 0;
	int unsigned stall_left = 0;
	int unsigned holds_done = 0;
	logic        long_hold = 1'b0;

	// Decoder model state
	phase_t      lit_phase = PH_OPEN;
	logic [2:0]  hex_seen = '0;
	logic [15:0] hex_buf [4];

	wire sender_calm   = (items_sent[8:7] == 2'd1);
	wire receiver_calm = (results_seen[8:7] == 2'd2);

	quoted_literal_unescape_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.unit_valid(unit_valid),
		.unit_stall(unit_stall),
		.unit_item (unit_item),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [15:0] upcase(input logic [15:0] c);
		if (c >= ASC_A_LO && c <= ASC_Z_LO) begin
			return c - ASC_CASE;
		end
		return c;
	endfunction

	// {is hex digit, digit value} of an uppercased unit
	function automatic logic [4:0] nibble_of(input logic [15:0] c);
		if (c >= ASC_0 && c <= ASC_9) begin
			return {1'b1, c[3:0]};
		end
		if (c >= ASC_A_UP && c <= ASC_F_UP) begin
			return {1'b1, c[3:0] + 4'd9};
		end
		return 5'd0;
	endfunction

	function automatic logic [15:0] escape_code(input logic [15:0] c);
		case (c)
			ASC_0:    return CTRL_NUL;
			ASC_A_LO: return CTRL_BEL;
			ASC_B_LO: return CTRL_BS;
			ASC_F_LO: return CTRL_FF;
			ASC_N_LO: return CTRL_LF;
			ASC_R_LO: return CTRL_CR;
			ASC_T_LO: return CTRL_HT;
			default:  return c;
		endcase
	endfunction

	// Value of the first n gathered hex units, skipping a leading 0X
	function automatic logic [15:0] hex_number(input int n);
		int          k;
		int          start;
		logic        stop;
		logic [4:0]  nib;
		logic [15:0] acc;
		acc = '0;
		stop = 1'b0;
		start = 0;
		if (n >= 2 && hex_buf[0] == ASC_0 && hex_buf[1] == ASC_X_UP) begin
			start = 2;
		end
		for (k = start; k < n; k++) begin
			nib = nibble_of(hex_buf[k]);
			if (!nib[4]) begin
				stop = 1'b1;
			end
			if (!stop) begin
				acc = {acc[11:0], nib[3:0]};
			end
		end
		return acc;
	endfunction

	// Advance the literal state by one unit and queue the item it yields
	task automatic decode_unit(input unit_item_t it);
		logic        have;
		logic [15:0] val;
		dec_item_t   res;
		have = 1'b0;
		val = '0;
		case (lit_phase)
			PH_BODY: begin
				if (!it.is_last) begin
					if (it.code_unit == ASC_BSLASH) begin
						lit_phase = PH_ESC;
					end else begin
						have = 1'b1;
						val = it.code_unit;
					end
				end
			end
			PH_ESC: begin
				if (it.code_unit == ASC_U_LO) begin
					hex_seen = '0;
					if (it.is_last) begin
						have = 1'b1;
					end else begin
						lit_phase = PH_HEX;
					end
				end else begin
					have = 1'b1;
					val = escape_code(it.code_unit);
					lit_phase = PH_BODY;
				end
			end
			PH_HEX: begin
				hex_buf[hex_seen[1:0]] = upcase(it.code_unit);
				hex_seen = hex_seen + 3'd1;
				if (hex_seen >= 3'd4 || it.is_last) begin
					have = 1'b1;
					val = hex_number(int'(hex_seen));
					hex_seen = '0;
					lit_phase = PH_BODY;
				end
			end
			default: begin
				lit_phase = PH_BODY;
			end
		endcase
		if (it.is_last) begin
			lit_phase = PH_OPEN;
		end
		if (have || it.is_last) begin
			res.decoded_unit = have ? val : 16'h0000;
			res.has_unit = have;
			res.end_of_literal = it.is_last;
			dec_expected = {dec_expected, res};
		end
	endtask

	task automatic queue_unit(input logic [15:0] cu, input logic last);
		unit_item_t it;
		it.code_unit = cu;
		it.is_last = last;
		unit_backlog = {unit_backlog, it};
		queued_units++;
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			queue_unit({8'h00, s[i]}, 1'b0);
		end
	endtask

	function automatic logic [15:0] plain_unit();
		if ($urandom_range(0, 9) < 7) begin
			return 16'($urandom_range(16'h0020, 16'h007E));
		end
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [15:0] hex_char(input logic [3:0] nib, input logic lower);
		if (nib < 4'd10) begin
			return ASC_0 + {12'd0, nib};
		end
		return (lower ? ASC_A_LO : ASC_A_UP) + {12'd0, nib} - 16'd10;
	endfunction

	function automatic logic [15:0] rand_hex_char();
		return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endfunction

	function automatic logic [15:0] non_hex_char();
		case ($urandom_range(0, 2))
			0:       return ASC_G_LO + 16'($urandom_range(0, 19));
			1:       return 16'($urandom_range(16'h003A, 16'h0040));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] escape_letter();
		case ($urandom_range(0, 11))
			0:       return ASC_0;
			1:       return ASC_A_LO;
			2:       return ASC_B_LO;
			3:       return ASC_F_LO;
			4:       return ASC_N_LO;
			5:       return ASC_R_LO;
			6:       return ASC_T_LO;
			7:       return ASC_BSLASH;
			8:       return ASC_QUOTE;
			9:       return ASC_DQUOTE;
			10:      return plain_unit();
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Build one literal; some are cut short, ending inside the body or an escape
	task automatic queue_literal();
		logic [15:0] lit[$];
		logic [15:0] cu;
		int unsigned n;
		int unsigned k;
		int unsigned j;
		int unsigned mode;
		int unsigned stop_at;
		int unsigned cut;
		case ($urandom_range(0, 9))
			0:       lit = {lit, ASC_QUOTE};
			1:       lit = {lit, 16'($urandom_range(0, 16'hFFFF))};
			default: lit = {lit, ASC_DQUOTE};
		endcase
		n = $urandom_range(0, 10);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: lit = {lit, plain_unit()};
				5, 6, 7: begin
					lit = {lit, ASC_BSLASH};
					lit = {lit, escape_letter()};
				end
				default: begin
					lit = {lit, ASC_BSLASH};
					lit = {lit, ASC_U_LO};
					mode = $urandom_range(0, 3);
					stop_at = $urandom_range(0, 3);
					for (j = 0; j < 4; j++) begin
						case (mode)
							0: cu = rand_hex_char();
							1: begin
								if (j == 0) begin
									cu = ASC_0;
								end else if (j == 1) begin
									cu = $urandom_range(0, 1) ? ASC_X_LO : ASC_X_UP;
								end else begin
									cu = rand_hex_char();
								end
							end
							2: cu = (j == stop_at) ? non_hex_char() : rand_hex_char();
							default: cu = $urandom_range(0, 1) ? rand_hex_char() : non_hex_char();
						endcase
						lit = {lit, cu};
					end
				end
			endcase
		end
		lit = {lit, ASC_DQUOTE};
		cut = lit.size() - 1;
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(0, lit.size() - 1);
		end
		for (k = 0; k <= cut; k++) begin
			queue_unit(lit[k], k == cut);
		end
	endtask

	// Loose units with random end marks
	task automatic queue_noise();
		int unsigned n;
		int unsigned k;
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			queue_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
		end
	endtask

	// Drive input items from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid <= 1'b0;
			unit_item <= '0;
			send_idle <= 0;
			items_sent <= '0;
		end else begin
			if (unit_valid && !unit_stall) begin
				decode_unit(unit_item);
				items_sent <= items_sent + 32'd1;
			end
			if (!unit_valid || !unit_stall) begin
				if (send_idle != 0) begin
					unit_valid <= 1'b0;
					send_idle <= send_idle - 1;
				end else if (unit_backlog.size() != 0) begin
					unit_item <= unit_backlog.pop_front();
					unit_valid <= 1'b1;
					send_idle <= (long_hold || sender_calm) ? 0 : idle_cycles();
				end else begin
					unit_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result channel: random runs plus two long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_stall <= 1'b0;
			stall_left <= 0;
			holds_done <= 0;
			long_hold <= 1'b0;
		end else if (stall_left != 0) begin
			dec_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 300 : 600)) begin
			dec_stall <= 1'b1;
			stall_left <= HOLD_CYCLES - 1;
			long_hold <= 1'b1;
			holds_done <= holds_done + 1;
		end else begin
			long_hold <= 1'b0;
			if (!receiver_calm && $urandom_range(0, 99) < 20) begin
				dec_stall <= 1'b1;
				stall_left <= idle_cycles();
			end else begin
				dec_stall <= 1'b0;
			end
		end
	end

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && dec_valid && !dec_stall) begin
			results_seen <= results_seen + 32'd1;
			if (dec_expected.size() == 0) begin
				$error("unexpected result item %h", dec_item);
				mismatches++;
			end else begin
				want_item = dec_expected.pop_front();
				if (dec_item.decoded_unit !== want_item.decoded_unit) begin
					$error("decoded_unit: expected %04h, got %04h",
						want_item.decoded_unit, dec_item.decoded_unit);
					mismatches++;
				end
				if (dec_item.has_unit !== want_item.has_unit) begin
					$error("has_unit: expected %b, got %b",
						want_item.has_unit, dec_item.has_unit);
					mismatches++;
				end
				if (dec_item.end_of_literal !== want_item.end_of_literal) begin
					$error("end_of_literal: expected %b, got %b",
						want_item.end_of_literal, dec_item.end_of_literal);
					mismatches++;
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		// single-unit literal at the top of the code range
		queue_unit(16'hFFFF, 1'b1);
		// every control escape but \t, 0X hex prefix, NUL in the body, backslash as closer
		queue_text("\"\\0\\a\\b\\f\\n\\r\\u0x1f");
		queue_unit(16'h0000, 1'b0);
		queue_unit(ASC_BSLASH, 1'b1);
		// literal ends inside the hex units, reading stops at a non-hex unit
		queue_text("\"\\u1");
		queue_unit(ASC_G_LO, 1'b1);
		// escape consumes the final unit
		queue_text("\"\\");
		queue_unit(ASC_T_LO, 1'b1);
		// literal ends right after u
		queue_text("\"\\");
		queue_unit(ASC_U_LO, 1'b1);

		while (queued_units < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_noise();
			end else begin
				queue_literal();
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all items to go in and every expected result to come out
		while (unit_backlog.size() != 0 || unit_valid) begin
			@(posedge clk);
		end
		while (dec_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(2.0 * CLK_HALF * LIMIT_CYCLES);
		$display("FAILURE");
		$finish;
	end

endmodule
